// ----- hdl/dmc_pkg.sv -----
package dmc_pkg;

    localparam int NumLines  = 64;
    localparam int MemWords  = 256;
    localparam int WordBits  = 32;
    localparam int AddrBits  = $clog2(MemWords);
    localparam int IndexBits = $clog2(NumLines);
    localparam int TagBits   = AddrBits - IndexBits;

    // Stream payload widths, rounded up to whole bytes, and the unrounded result width.
    localparam int SDataBits = ((AddrBits + WordBits + 7) / 8) * 8;
    localparam int ResBits   = WordBits + 2 + AddrBits;
    localparam int MDataBits = ((ResBits + 7) / 8) * 8;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                dirty;
        logic [TagBits-1:0]  tag;
        logic [WordBits-1:0] word;
    } t_line;

    // Packed from the lowest bit up: read_data, hit, wrote_back, evicted_address.
    typedef struct packed {
        logic [AddrBits-1:0] evicted_address;
        logic                wrote_back;
        logic                hit;
        logic [WordBits-1:0] read_data;
    } t_result;

    typedef struct packed {
        logic                rd_en;
        logic [AddrBits-1:0] rd_addr;
        logic                wr_en;
        logic [AddrBits-1:0] wr_addr;
        logic [WordBits-1:0] wr_data;
    } t_mem_req;

endpackage

// ----- hdl/dmc_backing_store.sv -----
module dmc_backing_store (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dmc_pkg::t_mem_req                    i_req,
    output logic [dmc_pkg::WordBits-1:0]         o_rd_data
);
    import dmc_pkg::*;

    logic [WordBits-1:0] r_mem [MemWords];
    logic [MemWords-1:0] r_written;
    logic [WordBits-1:0] r_rd_data;
    logic                r_rd_written;

    // A word that was never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// ----- hdl/direct_mapped_writeback_cache_core.sv -----
// Channel  | Direction | tdata (low bit up)                          | tuser
// ---------+-----------+---------------------------------------------+--------
// s_axis   | in        | address[7:0], write_data[31:0]              | command
// m_axis   | out       | read_data[31:0], hit, wrote_back,           | -
//          |           | evicted_address[7:0]                        |
//
// Every transaction passes through accept and memory read, tag check with
// line update and victim write-back, then hand-off to the output register.
// This split follows from the registered reads of the line and backing memories.
// Reset clears the line valid bits and the backing-store written bits.
// A stalled output holds the finished result; the next transaction is taken
// while it waits and completes once the output register is free.
module direct_mapped_writeback_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dmc_pkg::SDataBits-1:0]     s_axis_tdata,  // address, write_data
    input  logic [0:0]                        s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dmc_pkg::MDataBits-1:0]     m_axis_tdata   // read_data, hit,
                                                             // wrote_back, evicted_address
);
    import dmc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [IndexBits-1:0]  r_idx;
    logic [TagBits-1:0]    r_tag;
    logic [WordBits-1:0]   r_wdata;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_valid;

    t_line                 r_line_mem [NumLines];
    logic [NumLines-1:0]   r_line_valid;
    t_line                 r_line_rd;
    logic                  r_lv_rd;

    logic                  in_accept;
    logic [AddrBits-1:0]   in_addr;
    logic [IndexBits-1:0]  in_idx;
    logic [WordBits-1:0]   fill_word;
    logic                  lk_hit;
    logic                  lk_wb;
    logic [AddrBits-1:0]   lk_ev_addr;
    logic [WordBits-1:0]   base_word;
    t_line                 new_line;
    t_result               n_res;
    t_mem_req              mem_req;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_addr       = s_axis_tdata[AddrBits-1:0];
    assign in_idx        = in_addr[IndexBits-1:0];

    // Tag check and line update; a write-back and the fill never share an
    // address because the victim's tag differs from the request's.
    always_comb begin
        lk_hit     = r_lv_rd && (r_line_rd.tag == r_tag);
        lk_wb      = r_lv_rd && r_line_rd.dirty && !lk_hit;
        lk_ev_addr = {r_line_rd.tag, r_idx};
        base_word  = lk_hit ? r_line_rd.word : fill_word;
        new_line.tag = r_tag;
        if (r_cmd == CMD_WRITE) begin
            new_line.word  = r_wdata;
            new_line.dirty = 1'b1;
        end else begin
            new_line.word  = base_word;
            new_line.dirty = lk_hit && r_line_rd.dirty;
        end
        n_res.read_data       = (r_cmd == CMD_WRITE) ? '0 : new_line.word;
        n_res.hit             = lk_hit;
        n_res.wrote_back      = lk_wb;
        n_res.evicted_address = lk_wb ? lk_ev_addr : '0;
    end

    always_comb begin
        mem_req.rd_en   = in_accept;
        mem_req.rd_addr = in_addr;
        mem_req.wr_en   = (r_state == S_LOOK) && lk_wb;
        mem_req.wr_addr = lk_ev_addr;
        mem_req.wr_data = r_line_rd.word;
    end

    dmc_backing_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (fill_word)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_line_mem[r_idx] <= new_line;
        end
        if (in_accept) begin
            r_line_rd <= r_line_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= '0;
            r_lv_rd      <= 1'b0;
        end else begin
            if (r_state == S_LOOK) begin
                r_line_valid[r_idx] <= 1'b1;
            end
            if (in_accept) begin
                r_lv_rd <= r_line_valid[in_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= t_cmd'(s_axis_tuser[0]);
                        r_idx   <= in_idx;
                        r_tag   <= in_addr[AddrBits-1 -: TagBits];
                        r_wdata <= s_axis_tdata[AddrBits +: WordBits];
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_res   <= n_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(MDataBits - ResBits){1'b0}}, r_out};

    a_wb_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> !(lk_hit && lk_wb))
        else $error("write-back raised on a hit");

    a_wb_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (mem_req.wr_addr != {r_tag, r_idx}))
        else $error("victim write-back aimed at the address being filled");

    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOK))
        else $error("accepted transaction did not enter tag check");

    a_ev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.wrote_back) |-> (r_out.evicted_address == '0))
        else $error("evicted address set without a write-back");

endmodule

// ----- bench/tb_direct_mapped_writeback_cache_core.sv -----
module tb_direct_mapped_writeback_cache_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dmc_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 300;
    localparam int PhaseItems = 300;

    // Keeps a copy of the cache and its backing memory and queues the result
    // that each accepted access should produce.
    class cache_scoreboard;
        bit                 line_valid[NumLines];
        bit                 line_dirty[NumLines];
        bit [TagBits-1:0]   line_tag[NumLines];
        bit [WordBits-1:0]  line_word[NumLines];
        bit [WordBits-1:0]  mem_word[MemWords];
        t_result            expected_q[$];
        int unsigned        mismatches;

        function new();
            for (int i = 0; i < NumLines; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_tag[i]   = '0;
                line_word[i]  = '0;
            end
            for (int i = 0; i < MemWords; i++) begin
                mem_word[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void note_access(t_cmd cmd, logic [AddrBits-1:0] addr,
                                  logic [WordBits-1:0] wdata);
            logic [IndexBits-1:0] idx;
            logic [TagBits-1:0]   tag;
            logic [AddrBits-1:0]  victim;
            t_result              res;
            idx = addr[IndexBits-1:0];
            tag = addr[AddrBits-1:IndexBits];
            res = '0;
            res.hit = line_valid[idx] && (line_tag[idx] == tag);
            if (!res.hit) begin
                if (line_valid[idx] && line_dirty[idx]) begin
                    victim = {line_tag[idx], idx};
                    mem_word[victim] = line_word[idx];
                    res.wrote_back = 1'b1;
                    res.evicted_address = victim;
                end
                line_word[idx]  = mem_word[addr];
                line_tag[idx]   = tag;
                line_valid[idx] = 1'b1;
                line_dirty[idx] = 1'b0;
            end
            if (cmd == CMD_WRITE) begin
                line_word[idx]  = wdata;
                line_dirty[idx] = 1'b1;
            end else begin
                res.read_data = line_word[idx];
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: %h", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                mismatches++;
            end
            if (got.hit !== want.hit) begin
                $error("hit: expected %b, got %b", want.hit, got.hit);
                mismatches++;
            end
            if (got.wrote_back !== want.wrote_back) begin
                $error("wrote_back: expected %b, got %b", want.wrote_back, got.wrote_back);
                mismatches++;
            end
            if (got.evicted_address !== want.evicted_address) begin
                $error("evicted_address: expected %h, got %h",
                       want.evicted_address, got.evicted_address);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SDataBits-1:0] s_axis_tdata = '0;   // address, write_data
    logic [0:0]           s_axis_tuser = '0;   // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [MDataBits-1:0] m_axis_tdata;        // read_data, hit, wrote_back, evicted_address

    cache_scoreboard      cache_sb = new();
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    bit                   hold_request = 1'b0;
    int unsigned          hold_left = 0;
    int unsigned          cycle_count = 0;

    direct_mapped_writeback_cache_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            cache_sb.check_result(t_result'(m_axis_tdata[ResBits-1:0]));
        end
    end

    // Offers one access and returns at the edge where it is accepted.
    task automatic send_access(t_cmd cmd, logic [AddrBits-1:0] addr,
                               logic [WordBits-1:0] wdata);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wdata, addr};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        cache_sb.note_access(cmd, addr, wdata);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (cache_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Most accesses land on a few lines so that conflicts and write-backs
    // are frequent; the rest spread over the whole address space.
    task automatic send_random_access();
        logic [AddrBits-1:0]  addr;
        logic [IndexBits-1:0] idx;
        logic [TagBits-1:0]   tag;
        t_cmd                 cmd;
        cmd = t_cmd'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
            addr = AddrBits'($urandom_range(MemWords - 1));
        end else begin
            idx = ($urandom_range(1) == 0) ? IndexBits'($urandom_range(3))
                                           : IndexBits'(NumLines - 1 - $urandom_range(3));
            tag = TagBits'($urandom_range((1 << TagBits) - 1));
            addr = {tag, idx};
        end
        send_access(cmd, addr, WordBits'($urandom()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Cold miss, write hit, then read hit with write data to be ignored.
        send_access(CMD_READ,  8'd0,   32'h0000_0000);
        send_access(CMD_WRITE, 8'd0,   32'hFFFF_FFFF);
        send_access(CMD_READ,  8'd0,   32'hDEAD_BEEF);
        // Conflict on a dirty line writes the old word back.
        send_access(CMD_READ,  8'd64,  32'hFFFF_FFFF);
        // Conflict on a clean line refills the written-back word.
        send_access(CMD_READ,  8'd0,   32'h0000_0000);
        send_access(CMD_WRITE, 8'd255, 32'h0000_0000);
        send_access(CMD_WRITE, 8'd255, 32'hAAAA_AAAA);
        send_access(CMD_WRITE, 8'd191, 32'h5555_5555);
        send_access(CMD_READ,  8'd255, 32'hFFFF_FFFF);
        send_access(CMD_READ,  8'd191, 32'h0000_0000);
        send_access(CMD_WRITE, 8'd127, 32'h1234_5678);
        send_access(CMD_WRITE, 8'd63,  32'h8765_4321);
        send_access(CMD_READ,  8'd127, 32'h5A5A_5A5A);
        send_access(CMD_READ,  8'd63,  32'hA5A5_A5A5);
        send_access(CMD_WRITE, 8'd128, 32'h8000_0001);
        send_access(CMD_READ,  8'd128, 32'h0000_0000);
        send_access(CMD_WRITE, 8'd192, 32'h7FFF_FFFE);
        send_access(CMD_READ,  8'd128, 32'hFFFF_FFFF);
        wait_all_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                // Long output hold-off while the input keeps offering accesses.
                if (phase == 0 && n == 100) hold_request = 1'b1;
                send_random_access();
            end
            wait_all_results();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (cache_sb.mismatches == 0 && cache_sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
